// ===== hdl/vbci_pkg.sv =====
// shared types and constants for the voxel box corridor inflation unit
// no dependencies
package vbci_pkg;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_INFLATE = 1'b1;

  localparam logic [2:0] REG_EXTENT_X    = 3'd0;
  localparam logic [2:0] REG_EXTENT_Y    = 3'd1;
  localparam logic [2:0] REG_EXTENT_Z    = 3'd2;
  localparam logic [2:0] REG_ROUND_COUNT = 3'd3;
  localparam logic [2:0] REG_STEP_LENGTH = 3'd4;

  localparam int ROW_BITS = 64;

  typedef struct packed {
    logic        kind;
    logic [5:0]  seed_x;
    logic [5:0]  pos_y;
    logic [3:0]  pos_z;
    logic [63:0] row_bits;
  } vbci_cmd_t;

  typedef struct packed {
    logic [5:0] low_x;
    logic [5:0] low_y;
    logic [3:0] low_z;
    logic [5:0] high_x;
    logic [5:0] high_y;
    logic [3:0] high_z;
  } vbci_box_t;

endpackage

// ===== hdl/vbci_row_mem.sv =====
// occupancy row memory: one write port, one registered read port
// depends on vbci_pkg
module vbci_row_mem import vbci_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [ROW_BITS-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [ROW_BITS-1:0] rdata
);

  logic [ROW_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/voxel_box_corridor_inflation_unit.sv =====
// voxel box corridor inflation unit, top level; depends on vbci_pkg and vbci_row_mem
// a row write never raises busy
// an inflate tries each face in turn and scans each layer row by row through the one read port
// result_valid is high for a single cycle when the box is registered on result; no receiver stall
// synchronous active-high reset restores the registers to 64/64/16/20/2; memory not cleared
module voxel_box_corridor_inflation_unit import vbci_pkg::*; #(
  parameter int X_SIZE = 64,
  parameter int Y_SIZE = 64,
  parameter int Z_SIZE = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  vbci_cmd_t cmd,
  output logic      result_valid,
  output vbci_box_t result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int YW = (Y_SIZE > 1) ? $clog2(Y_SIZE) : 1;
  localparam int ZW = (Z_SIZE > 1) ? $clog2(Z_SIZE) : 1;
  localparam int AW = YW + ZW;
  localparam int CW = 9;  // coordinate width, holds up to 511

  // configuration registers
  logic [6:0] extent_x, extent_y;
  logic [4:0] extent_z, round_count;
  logic [2:0] step_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_x    <= 7'd64;
      extent_y    <= 7'd64;
      extent_z    <= 5'd16;
      round_count <= 5'd20;
      step_length <= 3'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXTENT_X:    extent_x    <= cfg_data[6:0];
        REG_EXTENT_Y:    extent_y    <= cfg_data[6:0];
        REG_EXTENT_Z:    extent_z    <= cfg_data[4:0];
        REG_ROUND_COUNT: round_count <= cfg_data[4:0];
        REG_STEP_LENGTH: step_length <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // extents clamped to 1..size
  logic [CW-1:0] ext_x, ext_y, ext_z;
  always_comb begin
    ext_x = (extent_x == 7'd0) ? CW'(1) :
            ((CW'(extent_x) > CW'(X_SIZE)) ? CW'(X_SIZE) : CW'(extent_x));
    ext_y = (extent_y == 7'd0) ? CW'(1) :
            ((CW'(extent_y) > CW'(Y_SIZE)) ? CW'(Y_SIZE) : CW'(extent_y));
    ext_z = (extent_z == 5'd0) ? CW'(1) :
            ((CW'(extent_z) > CW'(Z_SIZE)) ? CW'(Z_SIZE) : CW'(extent_z));
  end

  typedef enum logic [2:0] {S_IDLE, S_TRY, S_ISSUE, S_WAIT, S_EVAL, S_DONE} state_t;
  state_t state;

  // box bounds, index 0=x 1=y 2=z
  logic [CW-1:0] lo [3];
  logic [CW-1:0] hi [3];
  logic [2:0]    dir;      // 0..5: -y +y -x +x -z +z
  logic [4:0]    rnd;
  logic [CW-1:0] layer, limit, best;
  logic [CW-1:0] cy, cz;   // row scan position
  logic          hit;
  logic [ROW_BITS-1:0] mask;

  logic [ROW_BITS-1:0] rdata;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;

  // axis and direction of the current try
  logic [1:0] axis;
  logic       up;
  always_comb begin
    case (dir)
      3'd0: begin axis = 2'd1; up = 1'b0; end
      3'd1: begin axis = 2'd1; up = 1'b1; end
      3'd2: begin axis = 2'd0; up = 1'b0; end
      3'd3: begin axis = 2'd0; up = 1'b1; end
      3'd4: begin axis = 2'd2; up = 1'b0; end
      3'd5: begin axis = 2'd2; up = 1'b1; end
      default: begin axis = 2'd1; up = 1'b0; end
    endcase
  end

  // scan ranges of the current layer
  logic [CW-1:0] ly_lo, ly_hi, lz_lo, lz_hi, lx_lo, lx_hi;
  always_comb begin
    lx_lo = (axis == 2'd0) ? layer : lo[0];
    lx_hi = (axis == 2'd0) ? layer : hi[0];
    ly_lo = (axis == 2'd1) ? layer : lo[1];
    ly_hi = (axis == 2'd1) ? layer : hi[1];
    lz_lo = (axis == 2'd2) ? layer : lo[2];
    lz_hi = (axis == 2'd2) ? layer : hi[2];
  end

  logic [CW-1:0] cur_lo, cur_hi, cur_ext, st9;
  always_comb begin
    cur_lo  = lo[axis];
    cur_hi  = hi[axis];
    cur_ext = (axis == 2'd0) ? ext_x : ((axis == 2'd1) ? ext_y : ext_z);
    st9     = CW'(step_length);
  end

  // write port and read address
  assign we    = start && !busy && (cmd.kind == KIND_WRITE) &&
                 (32'(cmd.pos_y) < Y_SIZE) && (32'(cmd.pos_z) < Z_SIZE);
  assign waddr = {ZW'(cmd.pos_z), YW'(cmd.pos_y)};
  assign raddr = {cz[ZW-1:0], cy[YW-1:0]};

  vbci_row_mem #(.DEPTH(1 << AW), .AW(AW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cmd.row_bits),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy = (state != S_IDLE);

  logic [CW-1:0] sx, sy, sz;
  always_comb begin
    sx = (CW'(cmd.seed_x) < ext_x) ? CW'(cmd.seed_x) : ext_x - CW'(1);
    sy = (CW'(cmd.pos_y) < ext_y) ? CW'(cmd.pos_y) : ext_y - CW'(1);
    sz = (CW'(cmd.pos_z) < ext_z) ? CW'(cmd.pos_z) : ext_z - CW'(1);
  end

  logic row_last;
  assign row_last = (cy == ly_hi) && (cz == lz_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && cmd.kind == KIND_INFLATE) begin
            lo[0] <= sx; hi[0] <= sx;
            lo[1] <= sy; hi[1] <= sy;
            lo[2] <= sz; hi[2] <= sz;
            dir   <= 3'd0;
            rnd   <= 5'd0;
            state <= S_TRY;
          end
        end
        S_TRY: begin
          if (rnd == round_count) begin
            state <= S_DONE;
          end else begin
            if (up) begin
              limit <= (cur_hi + st9 > cur_ext - CW'(1)) ?
                       ((cur_ext - CW'(1) < cur_hi) ? cur_hi : cur_ext - CW'(1)) :
                       cur_hi + st9;
              layer <= cur_hi;
              best  <= cur_hi;
            end else begin
              limit <= (cur_lo >= st9) ? cur_lo - st9 : CW'(0);
              layer <= cur_lo;
              best  <= cur_lo;
            end
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          // new layer: set up mask and first row
          mask  <= ({ROW_BITS{1'b1}} >> (6'd63 - 6'(lx_hi - lx_lo))) << 6'(lx_lo);
          cy    <= ly_lo;
          cz    <= lz_lo;
          hit   <= 1'b0;
          state <= S_WAIT;
        end
        S_WAIT: begin
          // raddr holds this row; data arrives next cycle
          state <= S_EVAL;
        end
        S_EVAL: begin
          if ((rdata & mask) != '0 || hit) begin
            // layer blocked: commit best
            if (up) hi[axis] <= best; else lo[axis] <= best;
            dir   <= (dir == 3'd5) ? 3'd0 : dir + 3'd1;
            if (dir == 3'd5) rnd <= rnd + 5'd1;
            state <= S_TRY;
          end else if (!row_last) begin
            if (cy == ly_hi) begin
              cy <= ly_lo;
              cz <= cz + CW'(1);
            end else begin
              cy <= cy + CW'(1);
            end
            state <= S_WAIT;
          end else if (layer == limit) begin
            if (up) hi[axis] <= layer; else lo[axis] <= layer;
            dir   <= (dir == 3'd5) ? 3'd0 : dir + 3'd1;
            if (dir == 3'd5) rnd <= rnd + 5'd1;
            state <= S_TRY;
          end else begin
            best  <= layer;
            layer <= up ? layer + CW'(1) : layer - CW'(1);
            state <= S_ISSUE;
          end
        end
        S_DONE: begin
          result.low_x  <= lo[0][5:0];
          result.low_y  <= lo[1][5:0];
          result.low_z  <= lo[2][3:0];
          result.high_x <= hi[0][5:0];
          result.high_y <= hi[1][5:0];
          result.high_z <= hi[2][3:0];
          result_valid  <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // box stays ordered while working, checked at each face try
  a_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRY) |-> (lo[0] <= hi[0] && lo[1] <= hi[1] && lo[2] <= hi[2]))
    else $error("box bounds crossed");

  // a result follows only the done state
  a_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_DONE))
    else $error("result without completion");

  // no row write while a query runs
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    busy |-> !we)
    else $error("row write during query");

endmodule
